FILE: hw/rtl/glyph_text_blitter_unit_defines.svh
// ----------------------------------------------------------------------------
// glyph_text_blitter_unit_defines
// Assertion macros shared by the text blitter RTL.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_BLITTER_UNIT_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, held off during reset.
`define GTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtb assertion failed");

// Next-cycle implication, checked on clk, held off during reset.
`define GTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtb assertion failed");

`endif

FILE: hw/rtl/gtb_pkg.sv
// ----------------------------------------------------------------------------
// gtb_pkg
// Types and constants of the glyph text blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gtb_pkg;

  localparam int STORE_AW   = 14;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CHAR_CODES = 256;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR      = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_LINE_PITCH      = 16'd3072;
  localparam logic [3:0]  RST_BYTES_PER_PIXEL = 4'd3;
  localparam logic [3:0]  RST_GLYPH_WIDTH     = 4'd8;
  localparam logic [3:0]  RST_GLYPH_HEIGHT    = 4'd8;
  localparam logic [23:0] RST_FORE_COLOR      = 24'hCDD6F4;
  localparam logic [23:0] RST_BACK_COLOR      = 24'h1E1E2E;

  // Control characters
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_CR  = 8'h0D;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_SET_POS  = 2'd1,
    KIND_LOAD_BIT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] line_pitch;
    logic [3:0]  bytes_per_pixel;
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [23:0] fore_color;
    logic [23:0] back_color;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  code;
    logic [15:0] col;
    logic [15:0] row;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic                data;
  } store_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gtb_raster.sv
// ----------------------------------------------------------------------------
// gtb_raster
// Glyph store memory and the per-pixel walker that turns one glyph into
// framebuffer writes, with a read stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glyph_text_blitter_unit_defines.svh"

module gtb_raster #(
  parameter int MAX_GLYPH_W = 8,
  parameter int MAX_GLYPH_H = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gtb_pkg::cfg_t      cfg,
  input  wire gtb_pkg::job_t      job,
  input  wire gtb_pkg::store_wr_t wr,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_pixel_address,
  output logic [23:0]             out_pixel_color,
  output logic                    out_is_last
);

  localparam int WW = $clog2(MAX_GLYPH_W + 1);
  localparam int WH = $clog2(MAX_GLYPH_H + 1);
  localparam int WP = WW + WH;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_BASE = 4'b0100,
    ST_RUN  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [7:0]                  code_r;
  logic [15:0]                 col_r, row_r;
  logic [WP-1:0]               wh_r;
  logic [gtb_pkg::STORE_AW-1:0] idx_r;
  logic [31:0]                 row_addr_r, col_base_r, col_addr_r;
  logic [WW-1:0]               cnt_c_r;
  logic [WH-1:0]               cnt_r_r;

  logic [WW-1:0] eff_w;
  logic [WH-1:0] eff_h;
  logic [31:0]   row_prod;
  logic [19:0]   col_prod;
  logic [gtb_pkg::STORE_AW-1:0] base_idx;
  logic          last_col, last_row, last_pix;
  logic          issue, s1_move;

  logic                 glyph_mem [gtb_pkg::STORE_DEPTH];
  logic                 rdata_r;
  logic                 s1_valid_r;
  logic [31:0]          s1_addr_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  logic [31:0]          out_addr_r;
  logic [23:0]          out_color_r;
  logic                 out_last_r;

  assign eff_w = (cfg.glyph_width > MAX_GLYPH_W) ? WW'(MAX_GLYPH_W) : WW'(cfg.glyph_width);
  assign eff_h = (cfg.glyph_height > MAX_GLYPH_H) ? WH'(MAX_GLYPH_H) : WH'(cfg.glyph_height);

  assign row_prod = row_r * cfg.line_pitch;
  assign col_prod = col_r * cfg.bytes_per_pixel;
  assign base_idx = gtb_pkg::STORE_AW'(code_r * wh_r);

  assign last_col = (cnt_c_r == WW'(eff_w - 1'b1));
  assign last_row = (cnt_r_r == WH'(eff_h - 1'b1));
  assign last_pix = last_col && last_row;

  // One read per cycle while walking, as long as the read stage can drain.
  assign s1_move = s1_valid_r && (!out_valid_r || !out_stall);
  assign issue   = (state_r == ST_RUN) && (!s1_valid_r || s1_move);

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job.start) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_BASE;
      ST_BASE: begin
        state_nxt = (wh_r == '0) ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (issue && last_pix) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walker datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (job.start) begin
          code_r <= job.code;
          col_r  <= job.col;
          row_r  <= job.row;
        end
      end
      ST_PREP: begin
        wh_r       <= WP'(eff_w * eff_h);
        row_addr_r <= row_prod;
        col_base_r <= 32'(col_prod);
      end
      ST_BASE: begin
        idx_r      <= base_idx;
        col_addr_r <= col_base_r;
        cnt_c_r    <= '0;
        cnt_r_r    <= '0;
      end
      ST_RUN: begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
          if (last_col) begin
            cnt_c_r    <= '0;
            cnt_r_r    <= cnt_r_r + 1'b1;
            col_addr_r <= col_base_r;
            row_addr_r <= row_addr_r + 32'(cfg.line_pitch);
          end else begin
            cnt_c_r    <= cnt_c_r + 1'b1;
            col_addr_r <= col_addr_r + 32'(cfg.bytes_per_pixel);
          end
        end
      end
      default: ;
    endcase
  end

  // Glyph store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) glyph_mem[wr.addr] <= wr.data;
    if (issue) rdata_r <= glyph_mem[idx_r];
  end

  // Read stage: address waits here for the store data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr_r <= row_addr_r + col_addr_r;
      s1_last_r <= last_pix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_addr_r  <= s1_addr_r;
      out_color_r <= rdata_r ? cfg.fore_color : cfg.back_color;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_is_last       = out_last_r;

  `GTB_ASSERT_NEXT(a_last_read_ends_walk, issue && last_pix, state_r == ST_IDLE)
  `GTB_ASSERT_NOW(a_no_store_write_while_walking, wr.en, state_r == ST_IDLE)
  `GTB_ASSERT_NOW(a_read_stage_fed_by_read, $rose(s1_valid_r), $past(issue))

endmodule

`default_nettype wire

FILE: hw/rtl/glyph_text_blitter_unit.sv
// ----------------------------------------------------------------------------
// glyph_text_blitter_unit - bitmap font text renderer, one pixel write per cycle
// while not stalled. Glyph: accepted, setup in PREP and BASE, then w*h writes
// through the read stage and output register; the input stalls while walking.
// Other items do not make the unit busy. Sync active-low reset: cursor 0, default regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glyph_text_blitter_unit_defines.svh"

module glyph_text_blitter_unit #(
  parameter int MAX_GLYPH_W = 8,
  parameter int MAX_GLYPH_H = 8,
  parameter int GLYPH_COUNT = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [7:0]                     in_char_code,
  input  wire logic                           in_starts_string,
  input  wire logic [15:0]                    in_pos_x,
  input  wire logic [15:0]                    in_pos_y,
  input  wire logic [13:0]                    in_font_index,
  input  wire logic                           in_font_bit,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [31:0]                         out_pixel_address,
  output logic [23:0]                         out_pixel_color,
  output logic                                out_is_last,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [gtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gtb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WH = $clog2(MAX_GLYPH_H + 1);
  localparam int WW = $clog2(MAX_GLYPH_W + 1);

  // Configuration registers
  gtb_pkg::cfg_t cfg_r;

  // Cursor state
  logic [15:0] cursor_col_r, cursor_col_nxt;
  logic [15:0] cursor_row_r, cursor_row_nxt;
  logic [15:0] line_start_r, line_start_nxt;

  logic              accept;
  logic              busy;
  logic              is_blit;
  logic [WW-1:0]     eff_w;
  logic [WH-1:0]     eff_h;
  gtb_pkg::job_t      job;
  gtb_pkg::store_wr_t store_wr;

  // Character code to glyph slot, reduced modulo the glyph count.
  logic [7:0] glyph_sel_tab [gtb_pkg::CHAR_CODES];

  for (genvar gi = 0; gi < gtb_pkg::CHAR_CODES; gi++) begin : g_sel_tab
    assign glyph_sel_tab[gi] = 8'(gi % GLYPH_COUNT);
  end

  // Hold the input while a glyph is being walked; the walker owns the cursor
  // copy it was started with, so cursor updates happen right at acceptance.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // Saturate the glyph size to what the walker supports.
  assign eff_w = (cfg_r.glyph_width > MAX_GLYPH_W) ? WW'(MAX_GLYPH_W) : WW'(cfg_r.glyph_width);
  assign eff_h = (cfg_r.glyph_height > MAX_GLYPH_H) ? WH'(MAX_GLYPH_H) : WH'(cfg_r.glyph_height);

  // Printable means anything but the terminator, newline and carriage return.
  assign is_blit = (in_kind == gtb_pkg::KIND_CHAR) &&
                   (in_char_code != gtb_pkg::CHR_NUL) &&
                   (in_char_code != gtb_pkg::CHR_LF) &&
                   (in_char_code != gtb_pkg::CHR_CR);

  // Cursor update for one accepted transaction
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    line_start_nxt = line_start_r;
    if (accept) begin
      case (in_kind)
        gtb_pkg::KIND_CHAR: begin
          // latch the line start before the character is handled
          if (in_starts_string) line_start_nxt = cursor_col_r;
          case (in_char_code)
            gtb_pkg::CHR_NUL: ;
            gtb_pkg::CHR_LF: begin
              cursor_row_nxt = cursor_row_r + 16'(eff_h);
              cursor_col_nxt = line_start_nxt;
            end
            gtb_pkg::CHR_CR: begin
              cursor_col_nxt = line_start_nxt;
            end
            default: begin
              cursor_col_nxt = cursor_col_r + 16'(eff_w);
            end
          endcase
        end
        gtb_pkg::KIND_SET_POS: begin
          cursor_col_nxt = in_pos_x;
          cursor_row_nxt = in_pos_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      line_start_r <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      line_start_r <= line_start_nxt;
    end
  end

  // Configuration writes; unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_pitch      <= gtb_pkg::RST_LINE_PITCH;
      cfg_r.bytes_per_pixel <= gtb_pkg::RST_BYTES_PER_PIXEL;
      cfg_r.glyph_width     <= gtb_pkg::RST_GLYPH_WIDTH;
      cfg_r.glyph_height    <= gtb_pkg::RST_GLYPH_HEIGHT;
      cfg_r.fore_color      <= gtb_pkg::RST_FORE_COLOR;
      cfg_r.back_color      <= gtb_pkg::RST_BACK_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        gtb_pkg::REG_LINE_PITCH:      cfg_r.line_pitch      <= cfg_wdata[15:0];
        gtb_pkg::REG_BYTES_PER_PIXEL: cfg_r.bytes_per_pixel <= cfg_wdata[3:0];
        gtb_pkg::REG_GLYPH_WIDTH:     cfg_r.glyph_width     <= cfg_wdata[3:0];
        gtb_pkg::REG_GLYPH_HEIGHT:    cfg_r.glyph_height    <= cfg_wdata[3:0];
        gtb_pkg::REG_FORE_COLOR:      cfg_r.fore_color      <= cfg_wdata[23:0];
        gtb_pkg::REG_BACK_COLOR:      cfg_r.back_color      <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // Start the walker with the cursor as it stands before the advance.
  assign job.start = accept && is_blit;
  assign job.code  = glyph_sel_tab[in_char_code];
  assign job.col   = cursor_col_r;
  assign job.row   = cursor_row_r;

  // Glyph store loads go straight to the walker's memory.
  assign store_wr.en   = accept && (in_kind == gtb_pkg::KIND_LOAD_BIT);
  assign store_wr.addr = in_font_index;
  assign store_wr.data = in_font_bit;

  gtb_raster #(
    .MAX_GLYPH_W (MAX_GLYPH_W),
    .MAX_GLYPH_H (MAX_GLYPH_H)
  ) u_raster (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .job               (job),
    .wr                (store_wr),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_is_last       (out_is_last)
  );

  `GTB_ASSERT_NEXT(a_glyph_start_goes_busy, accept && is_blit, busy)
  `GTB_ASSERT_NEXT(a_stall_holds_cursor, in_valid && busy && !cfg_we,
                   $stable(cursor_col_r) && $stable(cursor_row_r))
  `GTB_ASSERT_NOW(a_no_accept_while_busy, busy, !accept)

endmodule

`default_nettype wire
